/* rtl/core/fmbs_pkg.sv */
// ============================================================================
// fmbs_pkg
// Shared sizes, register indexes and helpers for the first-match byte search.
// ============================================================================
`default_nettype none

package fmbs_pkg;

    localparam int MAX_NEEDLE_BYTES = 16;   // cells in the chain, 1..16
    localparam int POSITION_BITS    = 32;   // byte counter width, 8..48

    localparam int NEEDLE_WORD_BITS = 64;
    localparam int LEN_BITS         = 5;
    localparam int WINDOW_BITS      = 32;
    localparam int RESULT_POS_BITS  = 32;
    localparam int CFG_ADDR_BITS    = 3;
    localparam int CFG_DATA_BITS    = 64;
    localparam int IN_TDATA_BITS    = 8;
    localparam int OUT_TDATA_BITS   = 40;

    // compare width: room for the wider of counter and window, plus a carry
    localparam int CMP_BITS =
        ((POSITION_BITS > WINDOW_BITS) ? POSITION_BITS : WINDOW_BITS) + 1;

    localparam logic [CFG_ADDR_BITS-1:0] REG_NEEDLE_LOW  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NEEDLE_HIGH = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_NEEDLE_LEN  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WIN_START   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WIN_END     = 3'd4;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;    // word accepted: take the byte from the left neighbor
        logic in_use;   // this cell lies inside the needle length
    } cell_ctrl_t;

    // needle byte idx out of the two 64-bit registers
    function automatic logic [7:0] needle_byte_at(
        input logic [NEEDLE_WORD_BITS-1:0] lo,
        input logic [NEEDLE_WORD_BITS-1:0] hi,
        input logic [3:0]                  idx
    );
        logic [NEEDLE_WORD_BITS-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fmbs_cell.sv */
// ============================================================================
// fmbs_cell
// One stage of the byte history: holds a byte, compares the byte entering it.
// ============================================================================
`default_nettype none

module fmbs_cell (
    input  wire logic                aclk,
    input  wire fmbs_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]          byte_in,     // from left neighbor / stream
    input  wire logic [7:0]          needle_byte, // needle byte aligned to cell
    output logic [7:0]               byte_out,    // to right neighbor
    output logic                     match_ok
);
    import fmbs_pkg::*;

    logic [7:0] byte_reg;

    // byte_in is this cell's content after the shift
    assign match_ok = !ctrl.in_use || (byte_in == needle_byte);
    assign byte_out = byte_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/first_match_byte_search.sv */
// ============================================================================
// first_match_byte_search
// Streaming first-occurrence search of a short needle in a byte stream.
// ============================================================================
// Haystack bytes enter one per clock on the s_ stream; s_tlast marks the final
// byte. A row of MAX_NEEDLE_BYTES cells keeps the newest bytes and compares
// them in parallel with the needle, so a byte is taken every cycle that the
// result does not stall. When the final byte is accepted one result word
// leaves on the m_ stream the next cycle: found, and the start of the lowest
// match whose start is at or after window_start and whose last byte lies
// before window_end (position 0 when nothing was found). State then clears
// for the next haystack. The only stall is the result register: s_tready drops
// while a result waits and m_tready is low. Program the needle, length and
// window while the stream is idle. Needle length 0 or above the cell count
// never matches; the byte counter saturates at all ones.
// ============================================================================
`default_nettype none

module first_match_byte_search (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [fmbs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [fmbs_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    // haystack input
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [fmbs_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [7:0] hay_byte
    input  wire logic                                 s_tlast,   // last_byte
    // result output
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [fmbs_pkg::OUT_TDATA_BITS-1:0]       m_tdata    // [0] found,
                                                                 // [32:1] match_position
);
    import fmbs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [NEEDLE_WORD_BITS-1:0] needle_low_reg;
    logic [NEEDLE_WORD_BITS-1:0] needle_high_reg;
    logic [LEN_BITS-1:0]         needle_len_reg;
    logic [WINDOW_BITS-1:0]      win_start_reg;
    logic [WINDOW_BITS-1:0]      win_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
            win_start_reg   <= '0;
            win_end_reg     <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_NEEDLE_LOW:  needle_low_reg  <= cfg_wr_data;
                REG_NEEDLE_HIGH: needle_high_reg <= cfg_wr_data;
                REG_NEEDLE_LEN:  needle_len_reg  <= cfg_wr_data[LEN_BITS-1:0];
                REG_WIN_START:   win_start_reg   <= cfg_wr_data[WINDOW_BITS-1:0];
                REG_WIN_END:     win_end_reg     <= cfg_wr_data[WINDOW_BITS-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic s_acc;
    logic m_tvalid_reg, m_tvalid_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- cell chain ----------------
    // cell j sees the byte that will sit j places back after this word;
    // it is matched against needle byte (len-1-j)
    logic [7:0]                  chain   [MAX_NEEDLE_BYTES+1];
    logic [MAX_NEEDLE_BYTES-1:0] cell_ok;

    assign chain[0] = s_tdata[7:0];

    for (genvar j = 0; j < MAX_NEEDLE_BYTES; j++) begin : g_cell
        cell_ctrl_t          ctrl;
        logic [LEN_BITS-1:0] idx_full;

        assign idx_full    = needle_len_reg - LEN_BITS'(1) - LEN_BITS'(j);
        assign ctrl.shift  = s_acc;
        assign ctrl.in_use = LEN_BITS'(j) < needle_len_reg;

        fmbs_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .byte_in     (chain[j]),
            .needle_byte (needle_byte_at(needle_low_reg, needle_high_reg,
                                         idx_full[3:0])),
            .byte_out    (chain[j+1]),
            .match_ok    (cell_ok[j])
        );
    end

    // ---------------- position and window test ----------------
    logic [POSITION_BITS-1:0] byte_count_reg, byte_count_next;
    logic                     hit_seen_reg, hit_seen_next;
    logic [CMP_BITS-1:0]      hit_offset_reg, hit_offset_next;
    logic                     m_found_reg, m_found_next;
    logic [RESULT_POS_BITS-1:0] m_pos_reg, m_pos_next;

    logic                pos_sat, len_ok, long_enough, start_ok, end_ok, hit_now;
    logic [CMP_BITS-1:0] pos_p1, len_ext, start_pos;

    assign pos_sat     = &byte_count_reg;
    assign len_ok      = (needle_len_reg != '0) &&
                         (needle_len_reg <= LEN_BITS'(MAX_NEEDLE_BYTES));
    assign pos_p1      = CMP_BITS'(byte_count_reg) + CMP_BITS'(1);
    assign len_ext     = CMP_BITS'(needle_len_reg);
    assign long_enough = pos_p1 >= len_ext;
    assign start_pos   = pos_p1 - len_ext;
    assign start_ok    = start_pos >= CMP_BITS'(win_start_reg);
    assign end_ok      = pos_p1 <= CMP_BITS'(win_end_reg);
    assign hit_now     = !hit_seen_reg && len_ok && !pos_sat && long_enough &&
                         start_ok && end_ok && (&cell_ok);

    always_comb begin
        byte_count_next = byte_count_reg;
        hit_seen_next   = hit_seen_reg;
        hit_offset_next = hit_offset_reg;
        m_found_next    = m_found_reg;
        m_pos_next      = m_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        if (s_acc) begin
            if (s_tlast) begin
                // close the haystack: emit and clear
                m_tvalid_next   = 1'b1;
                m_found_next    = hit_seen_reg || hit_now;
                m_pos_next      = hit_now      ? start_pos[RESULT_POS_BITS-1:0] :
                                  hit_seen_reg ? hit_offset_reg[RESULT_POS_BITS-1:0] :
                                                 '0;
                byte_count_next = '0;
                hit_seen_next   = 1'b0;
                hit_offset_next = '0;
            end else begin
                if (!pos_sat) begin
                    byte_count_next = byte_count_reg + POSITION_BITS'(1);
                end
                if (hit_now) begin
                    hit_seen_next   = 1'b1;
                    hit_offset_next = start_pos;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            hit_seen_reg   <= 1'b0;
            hit_offset_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            hit_seen_reg   <= hit_seen_next;
            hit_offset_reg <= hit_offset_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_BITS-RESULT_POS_BITS-1)'(0), m_pos_reg, m_found_reg};

    // ---------------- assertions ----------------
    // a hit needs at least one counted byte
    a_hit_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_seen_reg |-> (byte_count_reg != '0))
        else $error("hit recorded with zero byte count");

    // final byte clears the search state
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (byte_count_reg == '0) && !hit_seen_reg)
        else $error("state not cleared after final byte");

    // first hit is never overwritten within a haystack
    a_first_hit_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_seen_reg && !(s_acc && s_tlast)) |=>
            hit_seen_reg && $stable(hit_offset_reg))
        else $error("first hit changed");

    // not found reports position zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_found_reg) |-> (m_pos_reg == '0))
        else $error("miss with nonzero position");

endmodule

`default_nettype wire
